// File: rtl/pls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

  localparam int OP_W = 3;
  localparam int POS_W = 7;
  localparam int COUNT_W = 7;
  localparam int DATA_W = 32;
  localparam int DEFAULT_CAPACITY = 64;

  localparam logic [DATA_W-1:0] READ_FAIL_VALUE = 32'h8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_READ       = 3'd0,
    OP_INS_HEAD   = 3'd1,
    OP_INS_TAIL   = 3'd2,
    OP_INS_AT     = 3'd3,
    OP_DEL_HEAD   = 3'd4,
    OP_DEL_TAIL   = 3'd5,
    OP_DEL_AT     = 3'd6,
    OP_UNUSED     = 3'd7
  } op_t;

  // what the storage engine is asked to do
  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_INS  = 2'd1,
    KIND_DEL  = 2'd2
  } kind_t;

  typedef struct packed {
    logic  go;
    kind_t kind;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/pls_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_engine #(
  parameter int CAPACITY = pls_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire pls_pkg::cmd_t                   cmd,
  input  wire logic [$clog2(CAPACITY)-1:0]     pos,
  input  wire logic [$clog2(CAPACITY+1)-1:0]   cnt,
  input  wire logic [pls_pkg::DATA_W-1:0]      value,
  output logic                                 busy,
  output logic                                 done,
  output logic [pls_pkg::DATA_W-1:0]           rdata
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RDW   = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t                      state, state_next;
  logic [AW-1:0]               addr, addr_next;
  logic [CW-1:0]               moves, moves_next;
  logic                        pend, pend_next;
  logic [AW-1:0]               waddr, waddr_next;
  logic                        ins, ins_next;
  logic [AW-1:0]               pos_r, pos_r_next;
  logic [pls_pkg::DATA_W-1:0]  val_r, val_r_next;

  logic [pls_pkg::DATA_W-1:0]  mem [CAPACITY];
  logic [pls_pkg::DATA_W-1:0]  q;

  logic                        re, we;
  logic [AW-1:0]               ra, wa;
  logic [pls_pkg::DATA_W-1:0]  wd;
  logic [CW-1:0]               cnt_m1;

  assign cnt_m1 = cnt - CW'(1);

  always_comb begin
    state_next = state;
    addr_next  = addr;
    moves_next = moves;
    pend_next  = pend;
    waddr_next = waddr;
    ins_next   = ins;
    pos_r_next = pos_r;
    val_r_next = val_r;
    re   = 1'b0;
    ra   = addr;
    we   = 1'b0;
    wa   = waddr;
    wd   = q;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd.go) begin
          pos_r_next = pos;
          val_r_next = value;
          pend_next  = 1'b0;
          case (cmd.kind)
            pls_pkg::KIND_READ: begin
              re         = 1'b1;
              ra         = pos;
              state_next = S_RDW;
            end
            pls_pkg::KIND_INS: begin
              // move entries pos..cnt-1 up by one, top first
              ins_next   = 1'b1;
              addr_next  = cnt_m1[AW-1:0];
              moves_next = cnt - CW'(pos);
              state_next = S_SHIFT;
            end
            default: begin
              // move entries pos+1..cnt-1 down by one, bottom first
              ins_next   = 1'b0;
              addr_next  = pos + AW'(1);
              moves_next = cnt_m1 - CW'(pos);
              state_next = S_SHIFT;
            end
          endcase
        end
      end
      S_RDW: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      S_SHIFT: begin
        // read one entry per cycle, write it back one place over in the next cycle
        if (pend) begin
          we = 1'b1;
          wa = waddr;
          wd = q;
        end
        if (moves != '0) begin
          re         = 1'b1;
          ra         = addr;
          addr_next  = ins ? addr - AW'(1) : addr + AW'(1);
          waddr_next = ins ? addr + AW'(1) : addr - AW'(1);
          moves_next = moves - CW'(1);
          pend_next  = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            if (ins) begin
              we = 1'b1;
              wa = pos_r;
              wd = val_r;
            end
            done       = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
    addr  <= addr_next;
    moves <= moves_next;
    waddr <= waddr_next;
    ins   <= ins_next;
    pos_r <= pos_r_next;
    val_r <= val_r_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      q <= mem[ra];
    end
  end

  assign busy  = (state != S_IDLE);
  assign rdata = q;

endmodule

`default_nettype wire

// File: rtl/positional_list_store_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Positional list store: an ordered list of signed 32-bit values, at most
// CAPACITY entries, kept packed in one RAM.
// Request channel: operation, position and item_value are taken at a clock
// edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle with ok, read_value and
// entry_count; the receiver cannot hold it off and the block does not wait.
// Occupancy:
//   rejected request or unknown operation: result the next cycle, busy stays
//   low, so such requests can go in every cycle.
//   read: busy while the engine reads the RAM; the result is then registered.
//   insert or delete: busy while the entries behind the point are moved.
// The busy time is set by the RAM's one read and one write per cycle: every
// entry behind the insert or delete point is moved once.
// Reset empties the list at once; the RAM contents are never cleared since
// only entries below the count are read.
module positional_list_store_top #(
  parameter int CAPACITY = pls_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [pls_pkg::OP_W-1:0]          operation,
  input  wire logic [pls_pkg::POS_W-1:0]         position,
  input  wire logic signed [pls_pkg::DATA_W-1:0] item_value,
  output logic                                   busy,
  output logic                                   done,
  output logic                                   ok,
  output logic signed [pls_pkg::DATA_W-1:0]      read_value,
  output logic [pls_pkg::COUNT_W-1:0]            entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W;
  localparam int OUT_W = pls_pkg::COUNT_W;

  logic [CW-1:0]    count, count_next;
  logic             accept;
  pls_pkg::op_t     op;
  logic [PW-1:0]    pos_w, cnt_w;
  logic             full, empty;
  logic             req_ok;
  pls_pkg::cmd_t    cmd;
  logic [PW-1:0]    place;
  logic             eng_busy, eng_done;
  logic [pls_pkg::DATA_W-1:0] eng_rdata;
  logic             pend_read;

  assign accept = start && !busy;
  assign op     = pls_pkg::op_t'(operation);
  assign pos_w  = PW'(position);
  assign cnt_w  = PW'(count);
  assign full   = (count == CW'(CAPACITY));
  assign empty  = (count == '0);

  always_comb begin
    req_ok     = 1'b0;
    place      = pos_w;
    cmd.kind   = pls_pkg::KIND_READ;
    count_next = count;
    case (op)
      pls_pkg::OP_READ: begin
        req_ok = (pos_w < cnt_w);
      end
      pls_pkg::OP_INS_HEAD: begin
        req_ok   = !full;
        place    = '0;
        cmd.kind = pls_pkg::KIND_INS;
      end
      pls_pkg::OP_INS_TAIL: begin
        req_ok   = !full;
        place    = cnt_w;
        cmd.kind = pls_pkg::KIND_INS;
      end
      pls_pkg::OP_INS_AT: begin
        req_ok   = !full && (pos_w <= cnt_w);
        cmd.kind = pls_pkg::KIND_INS;
      end
      pls_pkg::OP_DEL_HEAD: begin
        req_ok   = !empty;
        place    = '0;
        cmd.kind = pls_pkg::KIND_DEL;
      end
      pls_pkg::OP_DEL_TAIL: begin
        req_ok   = !empty;
        place    = cnt_w - PW'(1);
        cmd.kind = pls_pkg::KIND_DEL;
      end
      pls_pkg::OP_DEL_AT: begin
        req_ok   = (pos_w < cnt_w);
        cmd.kind = pls_pkg::KIND_DEL;
      end
      default: begin
        req_ok = 1'b0;
      end
    endcase
    cmd.go = accept && req_ok;
    if (cmd.go) begin
      case (cmd.kind)
        pls_pkg::KIND_INS: count_next = count + CW'(1);
        pls_pkg::KIND_DEL: count_next = count - CW'(1);
        default:           count_next = count;
      endcase
    end
  end

  pls_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .pos   (place[AW-1:0]),
    .cnt   (count),
    .value (item_value),
    .busy  (eng_busy),
    .done  (eng_done),
    .rdata (eng_rdata)
  );

  assign busy = eng_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= (accept && !req_ok) || eng_done;
    end
    if (cmd.go) begin
      pend_read <= (cmd.kind == pls_pkg::KIND_READ);
    end
    // results of rejected requests come straight back; accepted ones on engine completion
    if (accept && !req_ok) begin
      ok          <= 1'b0;
      read_value  <= (op == pls_pkg::OP_READ) ? pls_pkg::READ_FAIL_VALUE : '0;
      entry_count <= OUT_W'(count);
    end else if (eng_done) begin
      ok          <= 1'b1;
      read_value  <= pend_read ? eng_rdata : '0;
      entry_count <= OUT_W'(count);
    end
  end

  a_accept_answered: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted request neither in progress nor answered");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_engine_done_busy: assert property (@(posedge clk) disable iff (rst)
    eng_done |-> eng_busy)
    else $error("engine completion while idle");

  a_fail_value: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (read_value == '0 || read_value == pls_pkg::READ_FAIL_VALUE))
    else $error("bad read value on rejected request");

endmodule

`default_nettype wire
